### hdl/i2d_pkg.sv
// Shared types and constants for the integer to decimal string converter.
package i2d_pkg;

    localparam int MAG_W  = 32;              // magnitude width
    localparam int NDIG   = 10;              // decimal digits of a 32-bit magnitude
    localparam int BCD_W  = 4 * NDIG;
    localparam int IDX_W  = $clog2(NDIG);
    localparam int STEP_W = $clog2(MAG_W);
    localparam int WID_W  = 6;               // holds any width up to 32
    localparam int BODY_W = 4;               // sign plus digits, at most 11

    localparam logic [7:0] PAD_CHAR   = 8'h0B;
    localparam logic [7:0] MINUS_CHAR = 8'h2D;
    localparam logic [7:0] ZERO_CHAR  = 8'h30;

    typedef struct packed {
        logic [4:0]         min_width;
        logic signed [31:0] number;
    } t_in_word;

    typedef struct packed {
        logic [7:0] character;
        logic       final_char;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SETUP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic setup;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_sts;

endpackage

### hdl/integer_to_decimal_string.sv
// Top level: signed 32-bit integer to padded decimal ASCII characters.
//
//  channel | valid   | stall   | word
//  --------+---------+---------+------------------------------------------
//  input   | i_valid | o_stall | i_data: min_width, number
//  output  | o_valid | i_stall | o_data: character, final_char
//
// One number is accepted, converted by a 32-step shift-add-3 loop and laid out,
// then sent one character per cycle while the output does not stall, giving
// max(width, sign + digits) characters, at most MAX_WIDTH or 11.
// The BCD conversion loop takes the bulk of the time for each number.
// Reset is synchronous, active low, and clears the controller and o_valid.
// Output stalls hold the current word; the next number is taken once the
// previous string's last word is in the output register.
module integer_to_decimal_string #(
    parameter int MAX_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  i2d_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output i2d_pkg::t_out_word o_data
);
    import i2d_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    i2d_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .i_out_stall (i_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    i2d_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk  (i_clk),
        .i_data (i_data),
        .i_cmd  (cmd),
        .o_sts  (sts),
        .o_data (o_data)
    );

endmodule

### hdl/i2d_dp.sv
// Datapath: shift-add-3 binary to BCD, string layout and output word register.
module i2d_dp #(
    parameter int MAX_WIDTH = 16
) (
    input  logic              i_clk,
    input  i2d_pkg::t_in_word i_data,
    input  i2d_pkg::t_dp_cmd  i_cmd,
    output i2d_pkg::t_dp_sts  o_sts,
    output i2d_pkg::t_out_word o_data
);
    import i2d_pkg::*;

    localparam logic [WID_W-1:0] WIDTH_CAP = WID_W'(MAX_WIDTH);

    logic [MAG_W-1:0]           r_mag,   n_mag;
    logic [NDIG-1:0][3:0]       r_bcd,   n_bcd;
    logic                       r_neg,   n_neg;
    logic [WID_W-1:0]           r_width, n_width;
    logic [WID_W-1:0]           r_pad,   n_pad;
    logic                       r_sign,  n_sign;
    logic [IDX_W-1:0]           r_idx,   n_idx;
    t_out_word                  r_out,   n_out;

    logic [NDIG-1:0][3:0]       adj;
    logic [BCD_W-1:0]           adj_flat;
    logic [IDX_W-1:0]           top_idx;
    logic [BODY_W-1:0]          body;
    logic [WID_W-1:0]           body_ext;
    logic [WID_W-1:0]           in_width;
    logic [7:0]                 cur_char;
    logic                       cur_last;

    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
        adj_flat = adj;
    end

    // Highest nonzero digit; zero still shows one digit.
    always_comb begin
        top_idx = '0;
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[i] != 4'd0) begin
                top_idx = IDX_W'(i);
            end
        end
        body     = BODY_W'(top_idx) + BODY_W'(1) + BODY_W'(r_neg);
        body_ext = WID_W'(body);
    end

    assign in_width = ({1'b0, i_data.min_width} > WIDTH_CAP) ? WIDTH_CAP
                                                             : {1'b0, i_data.min_width};

    always_comb begin
        if (r_pad != '0) begin
            cur_char = PAD_CHAR;
        end else if (r_sign) begin
            cur_char = MINUS_CHAR;
        end else begin
            cur_char = ZERO_CHAR + {4'd0, r_bcd[r_idx]};
        end
        cur_last = (r_pad == '0) && !r_sign && (r_idx == '0);
    end

    assign o_sts.last = cur_last;

    always_comb begin
        n_mag   = r_mag;
        n_bcd   = r_bcd;
        n_neg   = r_neg;
        n_width = r_width;
        n_pad   = r_pad;
        n_sign  = r_sign;
        n_idx   = r_idx;
        n_out   = r_out;
        if (i_cmd.load) begin
            n_neg   = i_data.number[MAG_W-1];
            n_mag   = i_data.number[MAG_W-1] ? (~i_data.number + MAG_W'(1))
                                             : i_data.number;
            n_bcd   = '0;
            n_width = in_width;
        end
        if (i_cmd.step) begin
            n_bcd = {adj_flat[BCD_W-2:0], r_mag[MAG_W-1]};
            n_mag = {r_mag[MAG_W-2:0], 1'b0};
        end
        if (i_cmd.setup) begin
            n_idx  = top_idx;
            n_sign = r_neg;
            n_pad  = (r_width > body_ext) ? r_width - body_ext : '0;
        end
        if (i_cmd.emit) begin
            n_out.character  = cur_char;
            n_out.final_char = cur_last;
            // advance: padding, then sign, then digits downward
            if (r_pad != '0) begin
                n_pad = r_pad - WID_W'(1);
            end else if (r_sign) begin
                n_sign = 1'b0;
            end else if (r_idx != '0) begin
                n_idx = r_idx - IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag   <= n_mag;
        r_bcd   <= n_bcd;
        r_neg   <= n_neg;
        r_width <= n_width;
        r_pad   <= n_pad;
        r_sign  <= n_sign;
        r_idx   <= n_idx;
        r_out   <= n_out;
    end

    assign o_data = r_out;

endmodule

### hdl/i2d_ctrl.sv
// Controller: sequences conversion, layout and word emission, owns both handshakes.
module i2d_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output i2d_pkg::t_dp_cmd o_cmd,
    input  i2d_pkg::t_dp_sts i_sts
);
    import i2d_pkg::*;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_cnt,   n_cnt;
    logic                r_valid, n_valid;
    logic                out_free;

    assign out_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        n_valid = r_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + STEP_W'(1);
                if (r_cnt == STEP_W'(MAG_W - 1)) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_valid    = 1'b1;
                    if (i_sts.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_valid;

    a_emit_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (r_state == S_EMIT))
        else $error("emit outside emit state");

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!r_valid || !i_out_stall))
        else $error("emit would overwrite a stalled word");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_sts.last) |=> (r_state == S_IDLE) && r_valid)
        else $error("final word did not end the string");

    a_setup_after_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETUP) |-> ($past(r_state) == S_CONV)
                                && ($past(r_cnt) == STEP_W'(MAG_W - 1)))
        else $error("layout before conversion finished");

endmodule
